// ----- rtl/whla_pkg.sv -----
// Package for the weighted Hough line accumulator: types, codes and constants.
// Also holds the elaboration-time sine and cosine series used to build the angle ROM.
// Depends on nothing.
package whla_pkg;

  localparam int SUM_W     = 28;
  localparam int CNT_W     = 20;
  localparam int BOX_W     = 12;
  localparam int DIM_W     = 10;
  localparam int SCORE_W   = 12;
  localparam int SCORE_MAX = 4095;
  localparam int QUO_SAT   = 409;

  localparam logic [1:0] OP_VOTE  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE    = 3'd3;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] SIN_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                          64'd156, 64'd210};
  localparam logic [63:0] COS_DIV [8] = '{64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                          64'd132, 64'd182};

  // Neighborhood walk: the center first, then the eight neighbors.
  localparam logic [3:0] NB_LAST = 4'd8;
  localparam int NB_DT [16] = '{0, -1, -1, -1, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam int NB_DR [16] = '{0, -1, 0, 1, -1, 1, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0};

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [23:0] radius_scale;
    logic [11:0] min_score;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [BOX_W-1:0] col_min;
    logic [BOX_W-1:0] row_min;
    logic [DIM_W-1:0] col_max;
    logic [DIM_W-1:0] row_max;
  } bin_t;

  typedef struct packed {
    logic load_item;
    logic cnt_inc;
    logic clr_write;
    logic vote_issue;
    logic q_read;
    logic q_start;
    logic q_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last_bin;
    logic cnt_last_theta;
    logic vote_drained;
    logic nb_ok;
    logic nb_last;
    logic div_done;
    logic out_free;
  } sts_t;

  // Unsigned long division by shift and subtract, used only while building the ROM.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Magnitude of sine or cosine in Q1.14 for an angle in Q2.30, by an eight-term series.
  function automatic logic [15:0] taylor_q14(input logic [63:0] ang, input logic want_cos);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] rnd;
    logic signed [63:0] acc;
    a2 = (ang * ang) >> 30;
    term = want_cos ? ONE_Q30 : ang;
    acc = $signed(term);
    for (int k = 1; k <= 7; k++) begin
      term = long_div((term * a2) >> 30, want_cos ? COS_DIV[k] : SIN_DIV[k]);
      if (k[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > $signed(ONE_Q30)) begin
      acc = $signed(ONE_Q30);
    end
    rnd = 64'(acc) + 64'd32768;
    return 16'(rnd >> 16);
  endfunction

endpackage

// ----- rtl/weighted_hough_line_accumulator.sv -----
// Top level of the weighted Hough line accumulator: configuration registers,
// controller and datapath. Depends on whla_pkg, whla_ctrl and whla_dp.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  opcode, col, row, is_edge, edge_weight,
//                                           theta_index, radius_index
// out       output     out_valid/out_stall  out_theta, out_radius, score, is_line, box
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A vote does one table read-modify-write per angle bin through a one-write, one-read
// table and a four-stage radius pipeline.
// A query reads the bin and up to eight neighbors in turn, with one shared 28-step divider run per bin read.
// A clear, and the sweep after reset, write every bin, one bin a cycle.
// in_stall is high while an item is in progress; a waiting result does not block input.
module weighted_hough_line_accumulator #(
  parameter int THETA_BINS  = 180,
  parameter int RADIUS_BINS = 256,
  parameter int MAX_DIM     = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [9:0]  col,
  input  logic [9:0]  row,
  input  logic        is_edge,
  input  logic [7:0]  edge_weight,
  input  logic [7:0]  theta_index,
  input  logic [7:0]  radius_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_theta,
  output logic [7:0]  out_radius,
  output logic [11:0] score,
  output logic        is_line,
  output logic [9:0]  col_min,
  output logic [9:0]  row_min,
  output logic [9:0]  col_max,
  output logic [9:0]  row_max,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [whla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whla_pkg::CFG_DATA_W-1:0] cfg_data
);

  whla_pkg::cfg_t cfg;
  whla_pkg::cmd_t cmd;
  whla_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= 11'd640;
      cfg.image_height <= 11'd480;
      cfg.radius_scale <= 24'd20972;
      cfg.min_score <= 12'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        whla_pkg::REG_IMAGE_WIDTH:  cfg.image_width <= cfg_data[10:0];
        whla_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[10:0];
        whla_pkg::REG_RADIUS_SCALE: cfg.radius_scale <= cfg_data[23:0];
        whla_pkg::REG_MIN_SCORE:    cfg.min_score <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  whla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .opcode  (opcode),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  whla_dp #(
    .THETA_BINS (THETA_BINS),
    .RADIUS_BINS(RADIUS_BINS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .col         (col),
    .row         (row),
    .is_edge     (is_edge),
    .edge_weight (edge_weight),
    .theta_index (theta_index),
    .radius_index(radius_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_theta   (out_theta),
    .out_radius  (out_radius),
    .score       (score),
    .is_line     (is_line),
    .col_min     (col_min),
    .row_min     (row_min),
    .col_max     (col_max),
    .row_max     (row_max)
  );

  a_vote_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && opcode == whla_pkg::OP_VOTE) |=> in_stall)
    else $error("vote transfer did not hold off the next item");

  a_result_after_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

  a_query_after_votes: assert property (@(posedge clk) disable iff (rst)
    cmd.q_read |-> sts.vote_drained)
    else $error("query read while vote writes are in flight");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

endmodule

// ----- rtl/whla_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module whla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/whla_div.sv -----
// Restoring divider for bin scores, one quotient bit per cycle.
// Depends on whla_pkg.
module whla_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [whla_pkg::SUM_W-1:0] dividend,
  input  logic [whla_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [whla_pkg::SUM_W-1:0] quotient
);

  localparam int SW = whla_pkg::SUM_W;
  localparam int CW = whla_pkg::CNT_W;
  localparam int STW = $clog2(SW);

  logic          busy;
  logic [STW-1:0] step;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [CW:0]   shifted;
  logic          ge;

  assign shifted = {rem, quotient[SW-1]};
  assign ge = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? CW'(shifted - {1'b0, dvs}) : CW'(shifted);
      quotient <= {quotient[SW-2:0], ge};
    end
  end

endmodule

// ----- rtl/whla_dp.sv -----
// Datapath: angle ROM, radius pipeline, bin table, query scoring and result register.
// Depends on whla_pkg, whla_ram and whla_div.
module whla_dp #(
  parameter int THETA_BINS  = 180,
  parameter int RADIUS_BINS = 256,
  parameter int MAX_DIM     = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  whla_pkg::cfg_t      cfg,
  input  whla_pkg::cmd_t      cmd,
  output whla_pkg::sts_t      sts,
  input  logic [9:0]          col,
  input  logic [9:0]          row,
  input  logic                is_edge,
  input  logic [7:0]          edge_weight,
  input  logic [7:0]          theta_index,
  input  logic [7:0]          radius_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_theta,
  output logic [7:0]          out_radius,
  output logic [11:0]         score,
  output logic                is_line,
  output logic [9:0]          col_min,
  output logic [9:0]          row_min,
  output logic [9:0]          col_max,
  output logic [9:0]          row_max
);

  localparam int NBINS = THETA_BINS * RADIUS_BINS;
  localparam int AW    = $clog2(NBINS);
  localparam int TW    = $clog2(THETA_BINS);
  localparam int RW    = $clog2(RADIUS_BINS);
  localparam int HALF  = RADIUS_BINS / 2;
  localparam int BW    = $bits(whla_pkg::bin_t);

  logic signed [15:0] cos_tab [THETA_BINS];
  logic signed [15:0] sin_tab [THETA_BINS];

  for (genvar g = 0; g < THETA_BINS; g++) begin : g_rom
    localparam bit BACK = (2 * g > THETA_BINS);
    localparam int TP = BACK ? THETA_BINS - g : g;
    localparam logic [63:0] ANG = whla_pkg::PI_Q30 * 64'(TP) / 64'(THETA_BINS);
    localparam logic [15:0] SIN_V = whla_pkg::taylor_q14(ANG, 1'b0);
    localparam logic [15:0] COS_V = whla_pkg::taylor_q14(ANG, 1'b1);
    assign sin_tab[g] = SIN_V;
    assign cos_tab[g] = BACK ? -COS_V : COS_V;
  end

  logic [AW-1:0] cnt;
  logic signed [11:0] x_q;
  logic signed [11:0] y_q;
  logic [9:0] col_q;
  logic [9:0] row_q;
  logic edge_q;
  logic [7:0] weight_q;
  logic [TW-1:0] qt;
  logic [RW-1:0] qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load_item) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_q <= $signed(12'(col) - 12'(cfg.image_width[10:1]));
      y_q <= $signed(12'(row) - 12'(cfg.image_height[10:1]));
      col_q <= col;
      row_q <= row;
      edge_q <= is_edge;
      weight_q <= edge_weight;
      qt <= (32'(theta_index) > 32'(THETA_BINS - 1)) ? TW'(THETA_BINS - 1) : TW'(theta_index);
      qr <= (32'(radius_index) > 32'(RADIUS_BINS - 1)) ? RW'(RADIUS_BINS - 1)
                                                       : RW'(radius_index);
    end
  end

  logic [TW-1:0] s0_t;
  logic s1_v, s2_v, s3_v, s4_v;
  logic [TW-1:0] s1_t, s2_t, s3_t;
  logic signed [27:0] s1_px, s1_py;
  logic signed [28:0] r_sum;
  logic signed [28:0] r_abs;
  logic [25:0] s2_mag;
  logic s2_neg, s3_neg;
  logic [49:0] s3_prod;
  logic [49:0] rounded;
  logic [19:0] off;
  logic [RW-1:0] j;
  logic [AW-1:0] s3_addr, s4_addr;

  assign s0_t = cnt[TW-1:0];
  assign r_sum = 29'(s1_px) + 29'(s1_py);
  assign r_abs = r_sum[28] ? -r_sum : r_sum;
  assign rounded = s3_prod + 50'(64'd1 << 29);
  assign off = rounded[49:30];

  always_comb begin
    if (s3_neg) begin
      j = (32'(off) > 32'(HALF)) ? '0 : RW'(32'(HALF) - 32'(off));
    end else begin
      j = (32'(off) > 32'(RADIUS_BINS - 1 - HALF)) ? RW'(RADIUS_BINS - 1)
                                                   : RW'(32'(HALF) + 32'(off));
    end
  end

  assign s3_addr = AW'(32'(s3_t) * RADIUS_BINS) + AW'(j);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= cmd.vote_issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_t <= s0_t;
    s1_px <= x_q * cos_tab[s0_t];
    s1_py <= y_q * sin_tab[s0_t];
    s2_t <= s1_t;
    s2_neg <= r_sum[28];
    s2_mag <= r_abs[25:0];
    s3_t <= s2_t;
    s3_neg <= s2_neg;
    s3_prod <= 50'(s2_mag) * 50'(cfg.radius_scale);
    s4_addr <= s3_addr;
  end

  logic [TW-1:0] nt;
  logic [RW-1:0] nr;
  logic [3:0] nb;
  int dt, dr;
  logic [AW-1:0] q_addr;

  assign nb = cnt[3:0];
  assign dt = whla_pkg::NB_DT[nb];
  assign dr = whla_pkg::NB_DR[nb];
  assign nt = (dt < 0) ? qt - 1'b1 : (dt > 0) ? qt + 1'b1 : qt;
  assign nr = (dr < 0) ? qr - 1'b1 : (dr > 0) ? qr + 1'b1 : qr;
  assign q_addr = AW'(32'(nt) * RADIUS_BINS) + AW'(nr);

  whla_pkg::bin_t rd_bin, upd_bin, clr_bin;
  logic [BW-1:0] rdata;
  logic [28:0] sum_ext;
  logic we;
  logic [AW-1:0] waddr;
  logic [BW-1:0] wdata;

  assign rd_bin = whla_pkg::bin_t'(rdata);
  assign sum_ext = {1'b0, rd_bin.sum} + 29'(weight_q);

  always_comb begin
    clr_bin = '0;
    clr_bin.col_min = whla_pkg::BOX_W'(MAX_DIM - 1);
    clr_bin.row_min = whla_pkg::BOX_W'(MAX_DIM - 1);
  end

  always_comb begin
    upd_bin = rd_bin;
    if (rd_bin.cnt != '1) begin
      upd_bin.cnt = rd_bin.cnt + 1'b1;
    end
    if (edge_q) begin
      upd_bin.sum = sum_ext[28] ? '1 : sum_ext[27:0];
      if (whla_pkg::BOX_W'(col_q) < rd_bin.col_min) begin
        upd_bin.col_min = whla_pkg::BOX_W'(col_q);
      end
      if (whla_pkg::BOX_W'(row_q) < rd_bin.row_min) begin
        upd_bin.row_min = whla_pkg::BOX_W'(row_q);
      end
      if (col_q > rd_bin.col_max) begin
        upd_bin.col_max = col_q;
      end
      if (row_q > rd_bin.row_max) begin
        upd_bin.row_max = row_q;
      end
    end
  end

  assign we = cmd.clr_write | s4_v;
  assign waddr = cmd.clr_write ? cnt : s4_addr;
  assign wdata = cmd.clr_write ? BW'(clr_bin) : BW'(upd_bin);

  whla_ram #(
    .WIDTH(BW),
    .DEPTH(NBINS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.q_read | s3_v),
    .raddr(cmd.q_read ? q_addr : s3_addr),
    .rdata(rdata)
  );

  logic div_done;
  logic [whla_pkg::SUM_W-1:0] quo;
  logic [11:0] score_v;

  whla_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.q_start),
    .dividend(rd_bin.sum),
    .divisor (rd_bin.cnt == '0 ? whla_pkg::CNT_W'(1) : rd_bin.cnt),
    .done    (div_done),
    .quotient(quo)
  );

  assign score_v = (quo > whla_pkg::SUM_W'(whla_pkg::QUO_SAT)) ? 12'(whla_pkg::SCORE_MAX)
                                                               : 12'(12'(quo[8:0]) * 12'd10);

  logic [11:0] c_score;
  logic c_line;
  logic [9:0] c_cmin, c_rmin, c_cmax, c_rmax;

  always_ff @(posedge clk) begin
    if (cmd.q_start && nb == '0) begin
      c_cmin <= rd_bin.col_min[9:0];
      c_rmin <= rd_bin.row_min[9:0];
      c_cmax <= rd_bin.col_max;
      c_rmax <= rd_bin.row_max;
    end
    if (cmd.q_take) begin
      if (nb == '0) begin
        c_score <= score_v;
        c_line <= score_v >= cfg.min_score;
      end else if (score_v > c_score) begin
        c_line <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_theta <= 8'(qt);
      out_radius <= 8'(qr);
      score <= c_score;
      is_line <= c_line;
      col_min <= c_cmin;
      row_min <= c_rmin;
      col_max <= c_cmax;
      row_max <= c_rmax;
    end
  end

  always_comb begin
    sts.cnt_last_bin = cnt == AW'(NBINS - 1);
    sts.cnt_last_theta = cnt == AW'(THETA_BINS - 1);
    sts.vote_drained = !(s1_v | s2_v | s3_v | s4_v);
    sts.nb_ok = !((dt < 0) && qt == '0) && !((dt > 0) && qt == TW'(THETA_BINS - 1)) &&
                !((dr < 0) && qr == '0) && !((dr > 0) && qr == RW'(RADIUS_BINS - 1));
    sts.nb_last = nb == whla_pkg::NB_LAST;
    sts.div_done = div_done;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// ----- rtl/whla_ctrl.sv -----
// Controller state machine: sequences table clears, votes and bin queries.
// Depends on whla_pkg.
module whla_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     opcode,
  output logic           in_stall,
  input  whla_pkg::sts_t sts,
  output whla_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_VOTE  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_QRD   = 3'd4;
  localparam logic [2:0] S_QWAIT = 3'd5;
  localparam logic [2:0] S_QDIV  = 3'd6;
  localparam logic [2:0] S_QOUT  = 3'd7;

  logic [2:0] state, state_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_bin) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (opcode)
            whla_pkg::OP_VOTE:  state_next = S_VOTE;
            whla_pkg::OP_QUERY: state_next = S_QRD;
            whla_pkg::OP_CLEAR: state_next = S_CLEAR;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_VOTE: begin
        cmd.vote_issue = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_theta) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.vote_drained) begin
          state_next = S_IDLE;
        end
      end
      S_QRD: begin
        if (sts.nb_ok) begin
          cmd.q_read = 1'b1;
          state_next = S_QWAIT;
        end else if (sts.nb_last) begin
          state_next = S_QOUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_QWAIT: begin
        cmd.q_start = 1'b1;
        state_next = S_QDIV;
      end
      S_QDIV: begin
        if (sts.div_done) begin
          cmd.q_take = 1'b1;
          if (sts.nb_last) begin
            state_next = S_QOUT;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next = S_QRD;
          end
        end
      end
      S_QOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sim/weighted_hough_line_accumulator_tb.sv -----
// Testbench for the weighted Hough line accumulator: a scoreboard class that
// predicts every query answer from its own copy of the bin table, plus tasks
// that drive votes, queries, clears and register writes. Uses whla_pkg and the DUT.

module weighted_hough_line_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whla_pkg::*;

  localparam int NTHETA  = 180;
  localparam int NRADIUS = 256;
  localparam int NBIN    = NTHETA * NRADIUS;
  localparam int LIMIT   = 5000000;

  typedef struct {
    logic [1:0] opcode;
    logic [9:0] col;
    logic [9:0] row;
    logic       is_edge;
    logic [7:0] edge_weight;
    logic [7:0] theta_index;
    logic [7:0] radius_index;
  } hough_item_t;

  typedef struct packed {
    logic [7:0]  theta;
    logic [7:0]  radius;
    logic [11:0] score;
    logic        is_line;
    logic [9:0]  col_min;
    logic [9:0]  row_min;
    logic [9:0]  col_max;
    logic [9:0]  row_max;
  } line_answer_t;

  class hough_scoreboard;
    int unsigned  width, height, scale, min_score;
    int           cos_q14[NTHETA];
    int           sin_q14[NTHETA];
    int unsigned  sum_tab[NBIN];
    int unsigned  cnt_tab[NBIN];
    int unsigned  cmin_tab[NBIN];
    int unsigned  rmin_tab[NBIN];
    int unsigned  cmax_tab[NBIN];
    int unsigned  rmax_tab[NBIN];
    line_answer_t expected_answers[$];
    int           errors;

    function new();
      width = 640;
      height = 480;
      scale = 20972;
      min_score = 50;
      errors = 0;
      build_trig();
      clear_bins();
    endfunction

    function int to_q14(longint v);
      if (v < 0) v = 0;
      if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
      return int'((v + 32768) >>> 16);
    endfunction

    function void build_trig();
      longint unsigned a, a2, ts, tc, tp;
      longint          s, c;
      bit              back;
      for (int t = 0; t < NTHETA; t++) begin
        back = (2 * t) > NTHETA;
        tp = back ? NTHETA - t : t;
        a = PI_Q30 * tp / NTHETA;
        a2 = (a * a) >> 30;
        ts = a;
        tc = ONE_Q30;
        s = longint'(a);
        c = longint'(ONE_Q30);
        for (int k = 1; k <= 7; k++) begin
          ts = ((ts * a2) >> 30) / ((2 * k) * (2 * k + 1));
          tc = ((tc * a2) >> 30) / ((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            s = s - longint'(ts);
            c = c - longint'(tc);
          end else begin
            s = s + longint'(ts);
            c = c + longint'(tc);
          end
        end
        sin_q14[t] = to_q14(s);
        cos_q14[t] = back ? -to_q14(c) : to_q14(c);
      end
    endfunction

    function void clear_bins();
      for (int i = 0; i < NBIN; i++) begin
        sum_tab[i] = 0;
        cnt_tab[i] = 0;
        cmin_tab[i] = 1023;
        rmin_tab[i] = 1023;
        cmax_tab[i] = 0;
        rmax_tab[i] = 0;
      end
    endfunction

    function int radius_bin(int unsigned c, int unsigned r, int t);
      longint          x, y, rr, off, j;
      longint unsigned mag;
      x = longint'(c) - longint'(width >> 1);
      y = longint'(r) - longint'(height >> 1);
      rr = x * cos_q14[t] + y * sin_q14[t];
      mag = rr < 0 ? -rr : rr;
      off = longint'((mag * scale + (64'd1 << 29)) >> 30);
      j = NRADIUS / 2 + (rr < 0 ? -off : off);
      if (j < 0) j = 0;
      if (j > NRADIUS - 1) j = NRADIUS - 1;
      return int'(j);
    endfunction

    function int unsigned bin_score(int idx);
      int unsigned     d;
      longint unsigned s;
      d = cnt_tab[idx] == 0 ? 1 : cnt_tab[idx];
      s = longint'(sum_tab[idx] / d) * 10;
      return s > SCORE_MAX ? SCORE_MAX : int'(s);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_IMAGE_WIDTH: begin
          width = data[10:0];
        end
        REG_IMAGE_HEIGHT: begin
          height = data[10:0];
        end
        REG_RADIUS_SCALE: begin
          scale = data[23:0];
        end
        REG_MIN_SCORE: begin
          min_score = data[11:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_item(hough_item_t it);
      int           idx, t, r, nt, nr;
      int unsigned  sc, s;
      line_answer_t ans;
      if (it.opcode == OP_VOTE) begin
        for (int th = 0; th < NTHETA; th++) begin
          idx = th * NRADIUS + radius_bin(it.col, it.row, th);
          if (cnt_tab[idx] < 20'hFFFFF) cnt_tab[idx]++;
          if (it.is_edge) begin
            s = sum_tab[idx] + it.edge_weight;
            sum_tab[idx] = s > 28'hFFFFFFF ? 28'hFFFFFFF : s;
            if (it.col < cmin_tab[idx]) cmin_tab[idx] = it.col;
            if (it.row < rmin_tab[idx]) rmin_tab[idx] = it.row;
            if (it.col > cmax_tab[idx]) cmax_tab[idx] = it.col;
            if (it.row > rmax_tab[idx]) rmax_tab[idx] = it.row;
          end
        end
      end else if (it.opcode == OP_CLEAR) begin
        clear_bins();
      end else if (it.opcode == OP_QUERY) begin
        t = it.theta_index > NTHETA - 1 ? NTHETA - 1 : it.theta_index;
        r = it.radius_index;
        idx = t * NRADIUS + r;
        sc = bin_score(idx);
        ans.is_line = sc >= min_score;
        for (int dt = -1; dt <= 1; dt++) begin
          for (int dr = -1; dr <= 1; dr++) begin
            nt = t + dt;
            nr = r + dr;
            if ((dt != 0 || dr != 0) && nt >= 0 && nt < NTHETA && nr >= 0 && nr < NRADIUS)
              if (bin_score(nt * NRADIUS + nr) > sc) ans.is_line = 1'b0;
          end
        end
        ans.theta = t;
        ans.radius = r;
        ans.score = sc;
        ans.col_min = cmin_tab[idx];
        ans.row_min = rmin_tab[idx];
        ans.col_max = cmax_tab[idx];
        ans.row_max = rmax_tab[idx];
        expected_answers.insert(expected_answers.size(), ans);
      end
    endfunction

    function void check_answer(line_answer_t got);
      line_answer_t want;
      if (expected_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected answer transfer: theta %0d radius %0d",
                                   got.theta, got.radius);
        return;
      end
      want = expected_answers.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected t%0d r%0d s%0d l%0d box %0d,%0d-%0d,%0d got t%0d r%0d s%0d l%0d box %0d,%0d-%0d,%0d",
                   want.theta, want.radius, want.score, want.is_line, want.col_min,
                   want.row_min, want.col_max, want.row_max, got.theta, got.radius,
                   got.score, got.is_line, got.col_min, got.row_min, got.col_max,
                   got.row_max);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode = '0;
  logic [9:0]            col = '0;
  logic [9:0]            row = '0;
  logic                  is_edge = 1'b0;
  logic [7:0]            edge_weight = '0;
  logic [7:0]            theta_index = '0;
  logic [7:0]            radius_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_theta;
  logic [7:0]            out_radius;
  logic [11:0]           score;
  logic                  is_line;
  logic [9:0]            col_min;
  logic [9:0]            row_min;
  logic [9:0]            col_max;
  logic [9:0]            row_max;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hough_scoreboard sb = new();
  int              cycles = 0;
  int              burst_left = 0;
  int              stall_mode = 0;
  int              stall_cnt = 0;
  int unsigned     spot_col = 320;
  int unsigned     spot_row = 240;
  int unsigned     last_col = 0;
  int unsigned     last_row = 0;

  weighted_hough_line_accumulator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 96 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= (stall_cnt % 60) < 35;
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    line_answer_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_theta, out_radius, score, is_line, col_min, row_min, col_max, row_max};
      sb.check_answer(got);
    end
  end

  task automatic send_item(hough_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    burst_left--;
    opcode = it.opcode;
    col = it.col;
    row = it.row;
    is_edge = it.is_edge;
    edge_weight = it.edge_weight;
    theta_index = it.theta_index;
    radius_index = it.radius_index;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (it.opcode == OP_VOTE) begin
      last_col = it.col;
      last_row = it.row;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_index = index;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic hough_item_t make_item(logic [1:0] op, int c, int r, bit e, int w,
                                            int t, int rd);
    hough_item_t it;
    it = '{op, c[9:0], r[9:0], e, w[7:0], t[7:0], rd[7:0]};
    return it;
  endfunction

  function automatic hough_item_t random_item();
    int          p, t, rd;
    hough_item_t it;
    p = $urandom_range(0, 999);
    if (p < 2) return make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    if (p < 20) return make_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
    if (p < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        spot_col = $urandom_range(0, 1023);
        spot_row = $urandom_range(0, 1023);
      end
      if ($urandom_range(0, 1) == 0)
        return make_item(OP_VOTE, $urandom, $urandom, $urandom, $urandom, 0, 0);
      return make_item(OP_VOTE, (spot_col + $urandom_range(0, 6)) % 1024,
                       (spot_row + $urandom_range(0, 6)) % 1024,
                       $urandom_range(0, 4) != 0, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(0, 3) == 0)
      return make_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    t = $urandom_range(0, NTHETA - 1);
    rd = sb.radius_bin(last_col, last_row, t) + $urandom_range(0, 2) - 1;
    if (rd < 0) rd = 0;
    if (rd > NRADIUS - 1) rd = NRADIUS - 1;
    return make_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, t, rd);
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] phase_cfg[6][4];
    phase_cfg = '{'{640, 480, 20972, 50}, '{1, 1, 1, 0},
                  '{1024, 1024, 24'hFFFFFF, 2550}, '{1024, 1, 65536, 1},
                  '{0, 0, 0, 0}, '{640, 480, 20972, 50}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 1023, 1023, 1, 255, 255, 255));
    send_item(make_item(OP_VOTE, 0, 0, 1, 255, 0, 0));
    send_item(make_item(OP_VOTE, 1023, 1023, 1, 255, 0, 0));
    send_item(make_item(OP_VOTE, 0, 1023, 1, 0, 0, 0));
    send_item(make_item(OP_VOTE, 1023, 0, 0, 255, 0, 0));
    send_item(make_item(OP_VOTE, 320, 240, 1, 200, 0, 0));
    send_item(make_item(OP_VOTE, 320, 240, 1, 255, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 128));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 179, 128));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 90, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 255));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 179, 0));
    send_item(make_item(2'd3, 1023, 1023, 1, 255, 255, 255));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 128));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 4) begin
        phase_cfg[4] = '{$urandom_range(1, 1024), $urandom_range(1, 1024),
                         $urandom_range(8000, 60000), $urandom_range(0, 300)};
      end
      for (int k = 0; k < 4; k++) write_reg(k[CFG_IDX_W-1:0], phase_cfg[ph][k]);
      for (int n = 0; n < 300; n++) begin
        if (n == 150) drain();
        send_item(random_item());
      end
    end

    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
